>>> rtl/cmf_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cmf_pkg: shared types and constants for the Chaikin money flow block
// Widths of the bar fields, the sums and the divider, plus the command and
// status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package cmf_pkg;

  localparam int MAX_PERIOD     = 256;
  localparam int FRAC_BITS      = 16;
  localparam int DEFAULT_PERIOD = 20;

  localparam int PTR_W   = $clog2(MAX_PERIOD);
  localparam int LEN_W   = 9;
  localparam int PRICE_W = 32;
  localparam int VOL_W   = 32;

  // Multiplier magnitude, 0 .. 1.0 in Q.16, needs one integer bit.
  localparam int MUL_W   = FRAC_BITS + 1;
  localparam int PROD_W  = MUL_W + VOL_W;
  localparam int FLOW_W  = PROD_W + 1;
  localparam int FSUM_W  = 58;
  localparam int VSUM_W  = 40;
  localparam int RATIO_W = MUL_W + 1;

  // Price difference 2*close - low - high and its magnitude.
  localparam int DIFF_W = PRICE_W + 3;
  localparam int MAG_W  = PRICE_W + 2;

  localparam int DIV_NUM_W = FSUM_W;
  localparam int DIV_DEN_W = VSUM_W;
  localparam int DIV_CNT_W = $clog2(MUL_W + 2);

  localparam int RING_W = FLOW_W + VOL_W;

  localparam logic [MUL_W-1:0] ONE_Q = MUL_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic accept;
    logic cfg_write;
    logic prep;
    logic take_mult;
    logic mul;
    logic update;
    logic ratio_zero;
    logic ratio_start;
    logic take_ratio;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic vol_zero;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/cmf_bar_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cmf_bar_if: price bar channel
// Valid/ready channel carrying one bar per beat.
// ---------------------------------------------------------------------------
interface cmf_bar_if;
  logic                         valid;
  logic                         ready;
  logic [cmf_pkg::PRICE_W-1:0]  bar_high;
  logic [cmf_pkg::PRICE_W-1:0]  bar_low;
  logic [cmf_pkg::PRICE_W-1:0]  bar_close;
  logic [cmf_pkg::VOL_W-1:0]    bar_volume;
  logic                         first_bar;

  modport source (output valid, bar_high, bar_low, bar_close, bar_volume, first_bar,
                  input ready);
  modport sink (input valid, bar_high, bar_low, bar_close, bar_volume, first_bar,
                output ready);
endinterface
`default_nettype wire

>>> rtl/cmf_res_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cmf_res_if: money flow result channel
// Valid/ready channel carrying one result per beat.
// ---------------------------------------------------------------------------
interface cmf_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [cmf_pkg::RATIO_W-1:0] flow_ratio;
  logic [cmf_pkg::LEN_W-1:0]          window_length;

  modport source (output valid, flow_ratio, window_length, input ready);
  modport sink (input valid, flow_ratio, window_length, output ready);
endinterface
`default_nettype wire

>>> rtl/cmf_cfg_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cmf_cfg_if: configuration write channel
// Valid/ready channel carrying the window period register value.
// ---------------------------------------------------------------------------
interface cmf_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [cmf_pkg::LEN_W-1:0]  window_period;

  modport source (output valid, window_period, input ready);
  modport sink (input valid, window_period, output ready);
endinterface
`default_nettype wire

>>> rtl/chaikin_money_flow.sv
`default_nettype none
// ---------------------------------------------------------------------------
// chaikin_money_flow: Chaikin money flow over a sliding window of bars
// Top level joining the controller and the datapath.
// ---------------------------------------------------------------------------
// Usage:
// Each beat on in_bar carries one price bar (high, low, close, volume and a
// first-bar flag that restarts the series). Each bar produces exactly one beat
// on out_res: the window's money flow ratio in signed Q1.16 and the number of
// bars now in the window. A beat on cfg_wr sets the window period (0 acts as
// 1, values above 256 act as 256) and restarts the series.
// Processing: one bar is handled at a time. Both the multiplier and the
// window ratio may need the shared divider (17 restoring steps plus a
// rounding step a pass). A bar with an empty range or a close on or outside
// it, or a window whose volume sum is zero, skips a pass, and a bar may skip
// both. The next bar can be accepted the cycle after the result loads.
// Reset: the period returns to 20 and the window sums, fill count and ring
// pointer clear. The ring memory itself is not cleared; only entries written
// since the series started are ever read.
// Stalls: the result waits in the output register while out_res.ready is
// low, and a finished bar holds in its final step until that register frees.
// ---------------------------------------------------------------------------
module chaikin_money_flow (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cmf_bar_if.sink    in_bar,
  cmf_res_if.source  out_res,
  cmf_cfg_if.sink    cfg_wr
);
  import cmf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing of each bar.
  cmf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bar.valid),
    .in_ready  (in_bar.ready),
    .cfg_valid (cfg_wr.valid),
    .cfg_ready (cfg_wr.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Arithmetic, window state and the output register.
  cmf_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .bar_high      (in_bar.bar_high),
    .bar_low       (in_bar.bar_low),
    .bar_close     (in_bar.bar_close),
    .bar_volume    (in_bar.bar_volume),
    .first_bar     (in_bar.first_bar),
    .window_period (cfg_wr.window_period),
    .flow_ratio    (out_res.flow_ratio),
    .window_length (out_res.window_length)
  );

endmodule
`default_nettype wire

>>> rtl/cmf_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cmf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module cmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]              rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/cmf_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cmf_div: iterative restoring divider with rounding and cap
// Produces a Q.16 quotient, rounded half up and capped at one, one bit per cycle.
// ---------------------------------------------------------------------------
module cmf_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [cmf_pkg::DIV_NUM_W-1:0]    num,
  input  wire logic [cmf_pkg::DIV_DEN_W-1:0]    den,
  output logic                                  done,
  output logic [cmf_pkg::MUL_W-1:0]             quo
);
  import cmf_pkg::*;

  // The caller guarantees num < den * 2^MUL_W, so the top bits start below den.
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [MUL_W-1:0]     low_r;
  logic [MUL_W-1:0]     q_r;
  logic [MUL_W-1:0]     res_r;
  logic                 done_r;

  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 qbit;
  logic [DIV_DEN_W-1:0] rem_nxt;
  logic                 round_up;
  logic [MUL_W:0]       rounded;

  always_comb begin
    trial    = {rem_r, low_r[MUL_W-1]};
    diff     = trial - {1'b0, den_r};
    qbit     = ~diff[DIV_DEN_W];
    rem_nxt  = qbit ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
    round_up = ({rem_r, 1'b0} >= {1'b0, den_r});
    rounded  = {1'b0, q_r} + {{MUL_W{1'b0}}, round_up};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= num[MUL_W +: DIV_DEN_W];
        low_r <= num[MUL_W-1:0];
        den_r <= den;
        q_r   <= '0;
        cnt_r <= DIV_CNT_W'(MUL_W + 1);
      end else if (cnt_r > DIV_CNT_W'(1)) begin
        rem_r <= rem_nxt;
        low_r <= {low_r[MUL_W-2:0], 1'b0};
        q_r   <= {q_r[MUL_W-2:0], qbit};
        cnt_r <= cnt_r - DIV_CNT_W'(1);
      end else if (cnt_r == DIV_CNT_W'(1)) begin
        res_r  <= (rounded > {1'b0, ONE_Q}) ? ONE_Q : rounded[MUL_W-1:0];
        done_r <= 1'b1;
        cnt_r  <= '0;
      end
    end
  end

  assign done = done_r;
  assign quo  = res_r;

endmodule
`default_nettype wire

>>> rtl/cmf_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cmf_datapath: money flow datapath
// Bar registers, multiplier, window sums, ring memory, shared divider and
// the output register.
// ---------------------------------------------------------------------------
module cmf_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire cmf_pkg::cmd_t                     cmd,
  output cmf_pkg::sts_t                          sts,
  input  wire logic [cmf_pkg::PRICE_W-1:0]       bar_high,
  input  wire logic [cmf_pkg::PRICE_W-1:0]       bar_low,
  input  wire logic [cmf_pkg::PRICE_W-1:0]       bar_close,
  input  wire logic [cmf_pkg::VOL_W-1:0]         bar_volume,
  input  wire logic                              first_bar,
  input  wire logic [cmf_pkg::LEN_W-1:0]         window_period,
  output logic signed [cmf_pkg::RATIO_W-1:0]     flow_ratio,
  output logic [cmf_pkg::LEN_W-1:0]              window_length
);
  import cmf_pkg::*;

  logic [LEN_W-1:0]   period_r;
  logic [FSUM_W-1:0]  fsum_r;
  logic [VSUM_W-1:0]  vsum_r;
  logic [LEN_W-1:0]   bars_r;
  logic [PTR_W-1:0]   ptr_r;

  logic [PRICE_W-1:0] high_r;
  logic [PRICE_W-1:0] low_r;
  logic [PRICE_W-1:0] close_r;
  logic [VOL_W-1:0]   vol_r;
  logic [MUL_W-1:0]   mult_r;
  logic               mneg_r;
  logic [PROD_W-1:0]  prod_r;
  logic [RATIO_W-1:0] ratio_r;
  logic [RATIO_W-1:0] out_ratio_r;
  logic [LEN_W-1:0]   out_len_r;

  logic [PRICE_W-1:0]   hl;
  logic                 range_ok;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]    diff_abs;
  logic [MAG_W-1:0]     mag;
  logic                 mag_big;
  logic [LEN_W-1:0]     period_eff;
  logic [PTR_W-1:0]     old_addr;
  logic                 full;
  logic [FLOW_W-1:0]    flow;
  logic [RING_W-1:0]    ring_rd;
  logic [FLOW_W-1:0]    old_flow;
  logic [VOL_W-1:0]     old_vol;
  logic [FSUM_W-1:0]    fsum_nxt;
  logic [VSUM_W-1:0]    vsum_nxt;
  logic                 rneg;
  logic [FSUM_W-1:0]    rmag;
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [MUL_W-1:0]     div_quo;

  // Money flow multiplier operands.
  always_comb begin
    hl       = high_r - low_r;
    range_ok = (high_r > low_r);
    diff     = $signed({2'b00, close_r, 1'b0}) - $signed({3'b000, low_r})
               - $signed({3'b000, high_r});
    diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    mag      = diff_abs[MAG_W-1:0];
    mag_big  = (mag >= {2'b00, hl});
  end

  // Window bookkeeping.
  always_comb begin
    if (period_r == '0) begin
      period_eff = LEN_W'(1);
    end else if (period_r > LEN_W'(MAX_PERIOD)) begin
      period_eff = LEN_W'(MAX_PERIOD);
    end else begin
      period_eff = period_r;
    end
    old_addr = ptr_r - period_eff[PTR_W-1:0];
    full     = (bars_r >= period_eff);
    flow     = mneg_r ? FLOW_W'(-{1'b0, prod_r}) : {1'b0, prod_r};
    old_flow = ring_rd[RING_W-1 -: FLOW_W];
    old_vol  = ring_rd[VOL_W-1:0];
    fsum_nxt = fsum_r
               - (full ? {{(FSUM_W-FLOW_W){old_flow[FLOW_W-1]}}, old_flow} : '0)
               + {{(FSUM_W-FLOW_W){flow[FLOW_W-1]}}, flow};
    vsum_nxt = vsum_r
               - (full ? {{(VSUM_W-VOL_W){1'b0}}, old_vol} : '0)
               + {{(VSUM_W-VOL_W){1'b0}}, vol_r};
    rneg     = fsum_r[FSUM_W-1];
    rmag     = rneg ? (~fsum_r + FSUM_W'(1)) : fsum_r;
  end

  // The divider serves the multiplier first and the window ratio later.
  always_comb begin
    div_start = (cmd.prep && range_ok && !mag_big) || cmd.ratio_start;
    if (cmd.ratio_start) begin
      div_num = rmag;
      div_den = vsum_r;
    end else begin
      div_num = {{(DIV_NUM_W-MAG_W-FRAC_BITS){1'b0}}, mag, {FRAC_BITS{1'b0}}};
      div_den = {{(DIV_DEN_W-PRICE_W){1'b0}}, hl};
    end
  end

  cmf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  cmf_ram #(
    .WIDTH (RING_W),
    .DEPTH (MAX_PERIOD)
  ) u_ring (
    .clk     (clk),
    .wr_en   (cmd.update),
    .wr_addr (ptr_r),
    .wr_data ({flow, vol_r}),
    .rd_en   (cmd.prep),
    .rd_addr (old_addr),
    .rd_data (ring_rd)
  );

  // Control state: period register, sums, fill count and ring pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= LEN_W'(DEFAULT_PERIOD);
      fsum_r   <= '0;
      vsum_r   <= '0;
      bars_r   <= '0;
      ptr_r    <= '0;
    end else if (cmd.cfg_write) begin
      period_r <= window_period;
      fsum_r   <= '0;
      vsum_r   <= '0;
      bars_r   <= '0;
      ptr_r    <= '0;
    end else if (cmd.accept && first_bar) begin
      fsum_r <= '0;
      vsum_r <= '0;
      bars_r <= '0;
      ptr_r  <= '0;
    end else if (cmd.update) begin
      fsum_r <= fsum_nxt;
      vsum_r <= vsum_nxt;
      bars_r <= full ? bars_r : bars_r + LEN_W'(1);
      ptr_r  <= ptr_r + PTR_W'(1);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      high_r  <= bar_high;
      low_r   <= bar_low;
      close_r <= bar_close;
      vol_r   <= bar_volume;
    end
    if (cmd.prep) begin
      mneg_r <= range_ok && diff[DIFF_W-1];
      if (!range_ok) begin
        mult_r <= '0;
      end else if (mag_big) begin
        mult_r <= ONE_Q;
      end
    end
    if (cmd.take_mult && div_done) begin
      mult_r <= div_quo;
    end
    if (cmd.mul) begin
      prod_r <= mult_r * vol_r;
    end
    if (cmd.ratio_zero) begin
      ratio_r <= '0;
    end
    if (cmd.take_ratio && div_done) begin
      ratio_r <= rneg ? RATIO_W'(-{1'b0, div_quo}) : {1'b0, div_quo};
    end
    if (cmd.out_load) begin
      out_ratio_r <= ratio_r;
      out_len_r   <= bars_r;
    end
  end

  always_comb begin
    sts.need_div = range_ok && !mag_big;
    sts.div_done = div_done;
    sts.vol_zero = (vsum_r == '0);
  end

  assign flow_ratio    = $signed(out_ratio_r);
  assign window_length = out_len_r;

endmodule
`default_nettype wire

>>> rtl/cmf_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cmf_ctrl: money flow controller
// Sequences one bar through multiplier division, window update, ratio
// division and the output register.
// ---------------------------------------------------------------------------
module cmf_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output cmf_pkg::cmd_t       cmd,
  input  wire cmf_pkg::sts_t  sts
);
  import cmf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MDIV,
    S_MUL,
    S_UPD,
    S_RATIO,
    S_RDIV,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cfg_ready = (state_r == S_IDLE);
    in_ready  = (state_r == S_IDLE) && !cfg_valid;
    unique case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          cmd.cfg_write = 1'b1;
        end else if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = sts.need_div ? S_MDIV : S_MUL;
      end
      S_MDIV: begin
        cmd.take_mult = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_RATIO;
      end
      S_RATIO: begin
        if (sts.vol_zero) begin
          cmd.ratio_zero = 1'b1;
          state_nxt      = S_OUT;
        end else begin
          cmd.ratio_start = 1'b1;
          state_nxt       = S_RDIV;
        end
      end
      S_RDIV: begin
        cmd.take_ratio = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire
